// File: hdl/solenoid_pulse_burst_driver_top_defines.svh
// Assertion macros used by the solenoid driver control module.
`ifndef SOLENOID_PULSE_BURST_DRIVER_TOP_DEFINES_SVH
`define SOLENOID_PULSE_BURST_DRIVER_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising edge and disabled in reset.
`define SPBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("solenoid driver check failed");

// Next-cycle implication, checked on the rising edge and disabled in reset.
`define SPBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("solenoid driver check failed");

`endif

// File: hdl/spbd_pkg.sv
package spbd_pkg;

    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ON      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ON  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_OFF = CFG_IDX_W'(3);

    localparam logic [7:0]  MAX_ON_RESET      = 8'd25;
    localparam logic [7:0]  DEFAULT_ON_RESET  = 8'd18;
    localparam logic [15:0] DEFAULT_OFF_RESET = 16'd70;
    localparam logic [7:0]  LEVEL_BASE        = 8'd6;
    localparam logic [15:0] LEVEL_DIVISOR     = 16'd255;

    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_FIRE_ONCE  = 3'd1;
    localparam logic [2:0] OP_FIRE_BURST = 3'd2;
    localparam logic [2:0] OP_FIRE_LEVEL = 3'd3;
    localparam logic [2:0] OP_STOP       = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_GAP  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  shot_count;
        logic [15:0] pulse_on_ms;
        logic [15:0] pulse_off_ms;
        logic [7:0]  intensity;
    } item_t;

    typedef struct packed {
        logic drive;
        logic busy_res;
        logic status;
    } result_t;

    typedef struct packed {
        logic        enable;
        logic [7:0]  max_on_ms;
        logic [7:0]  default_on_ms;
        logic [15:0] default_off_ms;
    } cfg_t;

    function automatic logic [7:0] clamp_on(input logic [15:0] req, input logic [7:0] max_on);
        logic [7:0] top;
        logic [7:0] res;
        top = (max_on == 8'd0) ? 8'd1 : max_on;
        if (req == 16'd0)
        begin
            res = 8'd1;
        end
        else if (req > {8'd0, top})
        begin
            res = top;
        end
        else
        begin
            res = req[7:0];
        end
        return res;
    endfunction

    // The quotient by 255 uses the reciprocal 257/65536, which is never high and at
    // most one low for a 16-bit dividend, so one compare fixes it.
    function automatic logic [7:0] level_on(input logic [7:0] level, input logic [7:0] max_on,
                                            input logic [7:0] def_on);
        logic [7:0]  span;
        logic [15:0] prod;
        logic [24:0] scaled;
        logic [7:0]  quot;
        logic [15:0] rem;
        logic [7:0]  on;
        span   = (max_on > LEVEL_BASE) ? (max_on - LEVEL_BASE) : 8'd0;
        prod   = {8'd0, level} * {8'd0, span};
        scaled = {1'b0, prod, 8'd0} + {9'd0, prod};
        quot   = scaled[23:16];
        rem    = prod - ({quot, 8'd0} - {8'd0, quot});
        if (rem >= LEVEL_DIVISOR)
        begin
            quot = quot + 8'd1;
        end
        on = LEVEL_BASE + quot;
        if (on < def_on)
        begin
            on = def_on;
        end
        return clamp_on({8'd0, on}, max_on);
    endfunction

endpackage

// File: hdl/solenoid_pulse_burst_driver_top.sv
// An accepted item waits in the input register, and its result is registered in the
// output register. Throughput: one item per cycle while the output is not stalled;
// the burst state updates once per item.
// The input register holds an item while the output register is stalled.
// Reset is asynchronous and active low: the driver is disabled and idle,
// and the limits return to 25 ms on, 18 ms level floor and 70 ms gap.
module solenoid_pulse_burst_driver_top
    import spbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_wdata
);

    cfg_t    cfg;
    logic    clear;
    logic    advance;
    logic    held_valid;
    item_t   held_item;
    logic    go;
    result_t res;

    assign go = held_valid && advance;

    spbd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .clear     (clear)
    );

    spbd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    spbd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .item  (held_item),
        .cfg   (cfg),
        .clear (clear),
        .res   (res)
    );

    spbd_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (go),
        .res          (res),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: hdl/spbd_cfg.sv
module spbd_cfg
    import spbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_wdata,
    output cfg_t                 cfg,
    output logic                 clear
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:      cfg_next.enable         = cfg_wdata[0];
                CFG_MAX_ON:      cfg_next.max_on_ms      = cfg_wdata[7:0];
                CFG_DEFAULT_ON:  cfg_next.default_on_ms  = cfg_wdata[7:0];
                CFG_DEFAULT_OFF: cfg_next.default_off_ms = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable         <= 1'b0;
            cfg_reg.max_on_ms      <= MAX_ON_RESET;
            cfg_reg.default_on_ms  <= DEFAULT_ON_RESET;
            cfg_reg.default_off_ms <= DEFAULT_OFF_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg   = cfg_reg;
    assign clear = cfg_we && (cfg_index == CFG_ENABLE) && !cfg_wdata[0];

endmodule

// File: hdl/spbd_in_reg.sv
module spbd_in_reg
    import spbd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item,
    input  logic  advance,
    output logic  held_valid,
    output item_t held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign item_stall = valid_reg && !advance;
    assign load       = item_valid && !item_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// File: hdl/spbd_ctrl.sv
`include "solenoid_pulse_burst_driver_top_defines.svh"

module spbd_ctrl
    import spbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    go,
    input  item_t   item,
    input  cfg_t    cfg,
    input  logic    clear,
    output result_t res
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] remaining_reg;
    logic [15:0] remaining_next;
    logic [7:0]  wanted_reg;
    logic [7:0]  wanted_next;
    logic [7:0]  fired_reg;
    logic [7:0]  fired_next;
    logic [7:0]  on_time_reg;
    logic [7:0]  on_time_next;
    logic [15:0] off_time_reg;
    logic [15:0] off_time_next;
    logic        status;
    logic        do_launch;
    logic        do_finish;
    logic [7:0]  launch_on;
    logic [15:0] launch_off;
    logic [7:0]  launch_shots;

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        wanted_next    = wanted_reg;
        fired_next     = fired_reg;
        on_time_next   = on_time_reg;
        off_time_next  = off_time_reg;
        status         = 1'b0;
        do_launch      = 1'b0;
        do_finish      = 1'b0;
        launch_on      = clamp_on(item.pulse_on_ms, cfg.max_on_ms);
        launch_off     = cfg.default_off_ms;
        launch_shots   = 8'd1;

        if (go)
        begin
            case (item.operation)
                OP_TICK:
                begin
                    if (cfg.enable && (phase_reg != PH_IDLE))
                    begin
                        if (remaining_reg > 16'd1)
                        begin
                            remaining_next = remaining_reg - 16'd1;
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_ON:
                                begin
                                    if (fired_reg >= wanted_reg)
                                    begin
                                        do_finish = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next     = PH_GAP;
                                        remaining_next = off_time_reg;
                                    end
                                end
                                PH_GAP:
                                begin
                                    fired_next     = fired_reg + 8'd1;
                                    phase_next     = PH_ON;
                                    remaining_next = {8'd0, on_time_reg};
                                end
                                default: do_finish = 1'b1;
                            endcase
                        end
                    end
                end
                OP_FIRE_ONCE:
                begin
                    if (!cfg.enable)
                    begin
                        status = 1'b1;
                    end
                    else
                    begin
                        do_launch = 1'b1;
                    end
                end
                OP_FIRE_BURST:
                begin
                    if (!cfg.enable || (item.shot_count == 8'd0))
                    begin
                        status = 1'b1;
                    end
                    else
                    begin
                        do_launch    = 1'b1;
                        launch_shots = item.shot_count;
                        if (item.pulse_off_ms != 16'd0)
                        begin
                            launch_off = item.pulse_off_ms;
                        end
                    end
                end
                OP_FIRE_LEVEL:
                begin
                    if (item.intensity == 8'd0)
                    begin
                        do_finish = 1'b1;
                    end
                    else if (!cfg.enable)
                    begin
                        status = 1'b1;
                    end
                    else
                    begin
                        do_launch = 1'b1;
                        launch_on = level_on(item.intensity, cfg.max_on_ms,
                                             cfg.default_on_ms);
                    end
                end
                OP_STOP: do_finish = 1'b1;
                default: status = 1'b1;
            endcase
        end

        if (do_launch)
        begin
            on_time_next   = launch_on;
            off_time_next  = launch_off;
            wanted_next    = launch_shots;
            fired_next     = 8'd1;
            phase_next     = PH_ON;
            remaining_next = {8'd0, launch_on};
        end

        if (do_finish || clear)
        begin
            phase_next     = PH_IDLE;
            remaining_next = 16'd0;
            wanted_next    = 8'd0;
            fired_next     = 8'd0;
        end

        res.drive    = (phase_next == PH_ON);
        res.busy_res = (phase_next != PH_IDLE);
        res.status   = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            remaining_reg <= 16'd0;
            wanted_reg    <= 8'd0;
            fired_reg     <= 8'd0;
            on_time_reg   <= 8'd0;
            off_time_reg  <= 16'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            wanted_reg    <= wanted_next;
            fired_reg     <= fired_next;
            on_time_reg   <= on_time_next;
            off_time_reg  <= off_time_next;
        end
    end

    // A running burst has fired at least one pulse and never more than it asked for.
    `SPBD_ASSERT_NOW(a_shots_in_range, clk, rst_n, phase_reg != PH_IDLE,
        (fired_reg != 8'd0) && (fired_reg <= wanted_reg))

    // Idle always leaves the counters cleared.
    `SPBD_ASSERT_NOW(a_idle_cleared, clk, rst_n, phase_reg == PH_IDLE,
        (remaining_reg == 16'd0) && (fired_reg == 8'd0))

    // A fire-once command while disabled is rejected and leaves the phase alone.
    `SPBD_ASSERT_NEXT(a_disabled_fire, clk, rst_n,
        go && !cfg.enable && !clear && (item.operation == OP_FIRE_ONCE),
        phase_reg == $past(phase_reg))

endmodule

// File: hdl/spbd_out_reg.sv
module spbd_out_reg
    import spbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    advance,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign advance = !valid_reg || !result_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// File: test/tb_top.sv
module tb_top;
    import spbd_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam int         RUN_LIMIT    = 4000000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    item_t                item_data = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_wdata = '0;

    // Driver model state and its copy of the limit registers.
    logic        drv_enable = 1'b0;
    logic [7:0]  drv_max_on = MAX_ON_RESET;
    logic [7:0]  drv_default_on = DEFAULT_ON_RESET;
    logic [15:0] drv_default_off = DEFAULT_OFF_RESET;
    phase_t      drv_phase = PH_IDLE;
    logic [15:0] drv_remaining = '0;
    logic [7:0]  drv_shots_wanted = '0;
    logic [7:0]  drv_shots_fired = '0;
    logic [7:0]  drv_on_len = '0;
    logic [15:0] drv_gap_len = '0;
    logic        drv_pin = 1'b0;

    result_t     pin_levels_due[$];
    int          errors = 0;
    int          idle_pct = 20;
    int          stall_pct = 20;
    int          hold_len = 0;
    int          hold_left = 0;

    solenoid_pulse_burst_driver_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void end_burst();
        drv_pin = 1'b0;
        drv_phase = PH_IDLE;
        drv_remaining = '0;
        drv_shots_wanted = '0;
        drv_shots_fired = '0;
    endfunction

    function automatic logic [7:0] limit_on_time(input int unsigned req);
        int unsigned top;
        top = (drv_max_on == 8'd0) ? 1 : drv_max_on;
        if (req == 0)
        begin
            return 8'd1;
        end
        if (req > top)
        begin
            return top[7:0];
        end
        return req[7:0];
    endfunction

    function automatic void begin_shot();
        drv_shots_fired = drv_shots_fired + 8'd1;
        drv_phase = PH_ON;
        drv_pin = 1'b1;
        drv_remaining = {8'd0, drv_on_len};
    endfunction

    function automatic void start_burst(input int unsigned on_req, input logic [15:0] gap,
                                        input logic [7:0] shots);
        drv_on_len = limit_on_time(on_req);
        drv_gap_len = gap;
        drv_shots_wanted = shots;
        drv_shots_fired = '0;
        begin_shot();
    endfunction

    function automatic void interval_done();
        if (drv_phase == PH_ON)
        begin
            drv_pin = 1'b0;
            if (drv_shots_fired >= drv_shots_wanted)
            begin
                end_burst();
            end
            else
            begin
                drv_phase = PH_GAP;
                drv_remaining = drv_gap_len;
            end
        end
        else if (drv_phase == PH_GAP)
        begin
            begin_shot();
        end
        else
        begin
            end_burst();
        end
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [15:0] value);
        case (idx)
            CFG_ENABLE:
            begin
                drv_enable = value[0];
                if (!drv_enable)
                begin
                    end_burst();
                end
            end
            CFG_MAX_ON:      drv_max_on = value[7:0];
            CFG_DEFAULT_ON:  drv_default_on = value[7:0];
            CFG_DEFAULT_OFF: drv_default_off = value;
            default:         ;
        endcase
    endfunction

    function automatic result_t predict_pin_level(input item_t cmd);
        result_t     res;
        logic        rejected;
        int unsigned span;
        int unsigned level_on;
        rejected = 1'b0;
        case (cmd.operation)
            OP_TICK:
            begin
                if (drv_enable && drv_phase != PH_IDLE)
                begin
                    if (drv_remaining <= 16'd1)
                    begin
                        interval_done();
                    end
                    else
                    begin
                        drv_remaining = drv_remaining - 16'd1;
                    end
                end
            end
            OP_FIRE_ONCE:
            begin
                if (!drv_enable)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    start_burst(cmd.pulse_on_ms, drv_default_off, 8'd1);
                end
            end
            OP_FIRE_BURST:
            begin
                if (!drv_enable || cmd.shot_count == 8'd0)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    start_burst(cmd.pulse_on_ms,
                                (cmd.pulse_off_ms == 16'd0) ? drv_default_off : cmd.pulse_off_ms,
                                cmd.shot_count);
                end
            end
            OP_FIRE_LEVEL:
            begin
                if (cmd.intensity == 8'd0)
                begin
                    end_burst();
                end
                else if (!drv_enable)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    span = (drv_max_on > LEVEL_BASE) ? drv_max_on - LEVEL_BASE : 0;
                    level_on = LEVEL_BASE + (cmd.intensity * span) / LEVEL_DIVISOR;
                    if (level_on < drv_default_on)
                    begin
                        level_on = drv_default_on;
                    end
                    start_burst(level_on, drv_default_off, 8'd1);
                end
            end
            OP_STOP:
            begin
                end_burst();
            end
            default:
            begin
                rejected = 1'b1;
            end
        endcase
        res.drive = drv_pin;
        res.busy_res = (drv_phase != PH_IDLE);
        res.status = rejected;
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                apply_register(cfg_index, cfg_wdata);
            end
            if (item_valid && !item_stall)
            begin
                pin_levels_due.push_back(predict_pin_level(item_data));
            end
        end
    end

    task automatic compare_field(input string field, input logic want, input logic got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pin_levels_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %b", $time, result_data);
            end
            else
            begin
                want = pin_levels_due.pop_front();
                compare_field("drive", want.drive, result_data.drive);
                compare_field("busy_res", want.busy_res, result_data.busy_res);
                compare_field("status", want.status, result_data.status);
            end
        end
    end

    // The receiver stalls at random, or holds off for a requested number of cycles.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (hold_len > 0)
        begin
            hold_left = hold_len - 1;
            hold_len = 0;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        #RUN_LIMIT;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_item(input item_t cmd);
        int gap;
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 3);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_data <= cmd;
        item_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
    endtask

    task automatic send_op(input logic [2:0] op, input logic [7:0] shots,
                           input logic [15:0] on_ms, input logic [15:0] off_ms,
                           input logic [7:0] level);
        item_t cmd;
        cmd.operation = op;
        cmd.shot_count = shots;
        cmd.pulse_on_ms = on_ms;
        cmd.pulse_off_ms = off_ms;
        cmd.intensity = level;
        send_item(cmd);
    endtask

    task automatic wait_for_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pin_levels_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_registers(input logic en, input logic [7:0] max_on,
                                 input logic [7:0] def_on, input logic [15:0] def_off);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MAX_ON;
        cfg_wdata <= {8'd0, max_on};
        @(posedge clk);
        cfg_index <= CFG_DEFAULT_ON;
        cfg_wdata <= {8'd0, def_on};
        @(posedge clk);
        cfg_index <= CFG_DEFAULT_OFF;
        cfg_wdata <= def_off;
        @(posedge clk);
        cfg_index <= CFG_ENABLE;
        cfg_wdata <= {15'd0, en};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic item_t random_command();
        item_t       cmd;
        int unsigned pick;
        cmd = item_t'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            cmd.operation = OP_TICK;
        end
        else if (pick < 68)
        begin
            cmd.operation = OP_FIRE_ONCE;
        end
        else if (pick < 80)
        begin
            cmd.operation = OP_FIRE_BURST;
        end
        else if (pick < 88)
        begin
            cmd.operation = OP_FIRE_LEVEL;
        end
        else if (pick < 93)
        begin
            cmd.operation = OP_STOP;
        end
        if ($urandom_range(3) != 0)
        begin
            cmd.shot_count = 8'($urandom_range(4));
            cmd.pulse_on_ms = 16'($urandom_range(12));
            cmd.pulse_off_ms = 16'($urandom_range(6));
        end
        return cmd;
    endfunction

    task automatic random_items(input int count);
        repeat (count) send_item(random_command());
    endtask

    task automatic run_phase(input logic en, input logic [7:0] max_on,
                             input logic [7:0] def_on, input logic [15:0] def_off,
                             input int count);
        wait_for_results();
        set_registers(en, max_on, def_on, def_off);
        random_items(count);
    endtask

    task automatic test_disabled_commands();
        send_op(OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
        send_op(OP_FIRE_ONCE, 8'd1, 16'd10, 16'd0, 8'd0);
        send_op(OP_FIRE_BURST, 8'd3, 16'd10, 16'd5, 8'd0);
        send_op(OP_FIRE_LEVEL, 8'd0, 16'd0, 16'd0, 8'd0);
        send_op(OP_FIRE_LEVEL, 8'd0, 16'd0, 16'd0, 8'd9);
        send_op(OP_STOP, 8'd0, 16'd0, 16'd0, 8'd0);
    endtask

    task automatic test_fire_commands();
        wait_for_results();
        set_registers(1'b1, MAX_ON_RESET, DEFAULT_ON_RESET, DEFAULT_OFF_RESET);
        send_op(OP_FIRE_ONCE, 8'd0, 16'd0, 16'd0, 8'd0);
        send_op(OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
        send_op(OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
        send_op(OP_FIRE_ONCE, 8'd0, 16'hFFFF, 16'd0, 8'd0);
        send_op(OP_FIRE_LEVEL, 8'd0, 16'd0, 16'd0, 8'hFF);
        send_op(OP_FIRE_LEVEL, 8'd0, 16'd0, 16'd0, 8'd0);
        send_op(OP_FIRE_BURST, 8'd0, 16'd5, 16'd5, 8'd0);
        send_op(OP_FIRE_BURST, 8'd2, 16'd2, 16'd1, 8'd0);
        repeat (5) send_op(OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
        send_op(OP_FIRE_BURST, 8'hFF, 16'hFFFF, 16'hFFFF, 8'd0);
        for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
        begin
            send_op(op[2:0], 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        end
        send_op(OP_STOP, 8'd0, 16'd0, 16'd0, 8'd0);
    endtask

    // Dropping enable in the middle of a burst must end it at once.
    task automatic test_enable_drop();
        send_op(OP_FIRE_BURST, 8'd3, 16'd20, 16'd4, 8'd0);
        wait_for_results();
        set_registers(1'b0, MAX_ON_RESET, DEFAULT_ON_RESET, DEFAULT_OFF_RESET);
        send_op(OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
    endtask

    task automatic test_random_settings();
        run_phase(1'b1, MAX_ON_RESET, DEFAULT_ON_RESET, DEFAULT_OFF_RESET, 100);
        run_phase(1'b1, 8'd255, 8'd1, 16'd1, 100);
        run_phase(1'b1, 8'd6, 8'd255, 16'd2, 90);
        run_phase(1'b1, 8'd0, 8'd1, 16'hFFFF, 80);
        run_phase(1'b1, 8'd5, 8'd3, 16'd0, 90);
        run_phase(1'b0, 8'd12, 8'd4, 16'd3, 40);
        run_phase(1'b1, 8'($urandom), 8'($urandom_range(1, 40)),
                  16'($urandom_range(0, 8)), 120);
    endtask

    // A long run with neither side idling.
    task automatic test_full_rate();
        wait_for_results();
        idle_pct = 0;
        stall_pct = 0;
        set_registers(1'b1, 8'($urandom_range(6, 40)), 8'($urandom_range(1, 30)),
                      16'($urandom_range(1, 5)));
        random_items(120);
        idle_pct = 20;
        stall_pct = 20;
    endtask

    task automatic test_backpressure();
        run_phase(1'b1, 8'd20, 8'd8, 16'd3, 0);
        hold_len = 80;
        random_items(40);
        wait_for_results();
        random_items(40);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_disabled_commands();
        test_fire_commands();
        test_enable_drop();
        test_random_settings();
        test_full_rate();
        test_backpressure();
        wait_for_results();
        repeat (10) @(posedge clk);
        if (errors == 0 && pin_levels_due.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
